// ----- src/hftd_pkg.sv -----
// Shared types and constants of the level-order Huffman tree loader and decoder.
// Used by hftd_front, hftd_back and the top level; depends on nothing.
package hftd_pkg;

    localparam int MAX_SYMBOLS = 256;
    localparam int MAX_NODES   = 512;

    localparam int SYM_W    = 8;
    localparam int SYM_AW   = $clog2(MAX_SYMBOLS);
    localparam int SYM_CW   = $clog2(MAX_SYMBOLS + 1);
    localparam int NODE_AW  = $clog2(MAX_NODES);
    localparam int NODE_CW  = $clog2(MAX_NODES + 1);
    localparam int NODE_W   = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_SYMBOL = 2'd0,
        KIND_SHAPE  = 2'd1,
        KIND_CODE   = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_EARLY_CODE = 2'd1,
        ERR_SHAPE_OVF  = 2'd2,
        ERR_NO_SYMBOL  = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_LEAF_WR  = 4'b0010,
        ST_CUR_RD   = 4'b0100,
        ST_CHILD_RD = 4'b1000
    } t_state;

    typedef struct packed {
        t_kind            kind;
        logic             bit_req;
        logic [SYM_W-1:0] sym;
    } t_cmd;

endpackage

// ----- src/hftd_front.sv -----
// Front end: accepts requests, classifies them into commands and queues them.
// Depends on hftd_pkg.
module hftd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      i_kind,
    input  logic            i_bit_req,
    input  logic [7:0]      i_symbol,
    output logic            o_cmd_valid,
    output hftd_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_pop
);
    import hftd_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    t_cmd              cls_cmd;
    logic              push;

    // Classification: only the fields that matter to a command kind are kept.
    always_comb begin
        cls_cmd.kind    = t_kind'(i_kind);
        cls_cmd.bit_req = 1'b0;
        cls_cmd.sym     = '0;
        case (t_kind'(i_kind))
            KIND_SYMBOL: begin
                cls_cmd.sym = i_symbol;
            end
            KIND_SHAPE, KIND_CODE: begin
                cls_cmd.bit_req = i_bit_req;
            end
            default: begin
            end
        endcase
    end

    assign busy        = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push        = start && !busy;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push      ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = i_cmd_pop ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_cmd_pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (!push && i_cmd_pop) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_cmd_pop) |=> r_count == QCNT_W'($past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ----- src/hftd_back.sv -----
// Back end: executes queued commands against the symbol list and node table.
// Depends on hftd_pkg.
module hftd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  hftd_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_res_valid,
    output logic [7:0]           o_res_sym,
    output hftd_pkg::t_err       o_res_err
);
    import hftd_pkg::*;

    logic [SYM_W-1:0]  symbol_list [MAX_SYMBOLS];
    logic [NODE_W-1:0] node_table  [MAX_NODES];

    t_state              r_state, n_state;
    logic [SYM_CW-1:0]   r_loaded, n_loaded;
    logic [SYM_CW-1:0]   r_leaves, n_leaves;
    logic [NODE_CW-1:0]  r_shaped, n_shaped;
    logic [NODE_CW-1:0]  r_alloc, n_alloc;
    logic [NODE_AW-1:0]  r_cur, n_cur;
    logic [NODE_AW-1:0]  r_child, n_child;
    logic                r_bit, n_bit;
    logic                r_res_valid, n_res_valid;
    logic [SYM_W-1:0]    r_res_sym, n_res_sym;
    t_err                r_res_err, n_res_err;
    logic [SYM_W-1:0]    r_sym_rd;
    logic [NODE_W-1:0]   r_node_rd;

    logic                sym_we;
    logic [SYM_AW-1:0]   sym_waddr, sym_raddr;
    logic                node_we;
    logic [NODE_AW-1:0]  node_waddr, node_raddr;
    logic [NODE_W-1:0]   node_wdata;
    logic [NODE_AW-1:0]  child;
    logic                complete;

    assign complete  = (r_shaped == r_alloc);
    assign o_cmd_pop = i_cmd_valid && (r_state == ST_IDLE);
    assign child     = r_node_rd[NODE_AW-1:0] + NODE_AW'(r_bit);

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_leaves    = r_leaves;
        n_shaped    = r_shaped;
        n_alloc     = r_alloc;
        n_cur       = r_cur;
        n_child     = r_child;
        n_bit       = r_bit;
        n_res_valid = 1'b0;
        n_res_sym   = '0;
        n_res_err   = ERR_OK;
        sym_we      = 1'b0;
        sym_waddr   = r_loaded[SYM_AW-1:0];
        sym_raddr   = r_leaves[SYM_AW-1:0];
        node_we     = 1'b0;
        node_waddr  = r_shaped[NODE_AW-1:0];
        node_wdata  = '0;
        node_raddr  = r_cur;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        KIND_SYMBOL: begin
                            if (r_loaded < SYM_CW'(MAX_SYMBOLS)) begin
                                sym_we   = 1'b1;
                                n_loaded = SYM_CW'(r_loaded + 1'b1);
                            end
                        end
                        KIND_CLEAR: begin
                            n_loaded = '0;
                            n_leaves = '0;
                            n_shaped = '0;
                            n_alloc  = NODE_CW'(1);
                            n_cur    = '0;
                        end
                        KIND_SHAPE: begin
                            if (complete || r_shaped >= NODE_CW'(MAX_NODES)) begin
                                n_res_valid = 1'b1;
                                n_res_err   = ERR_SHAPE_OVF;
                            end else if (i_cmd.bit_req) begin
                                if (r_leaves >= r_loaded ||
                                    r_leaves >= SYM_CW'(MAX_SYMBOLS)) begin
                                    n_res_valid = 1'b1;
                                    n_res_err   = ERR_NO_SYMBOL;
                                end else begin
                                    // The symbol read is under way; write the leaf next.
                                    n_state = ST_LEAF_WR;
                                end
                            end else if ((NODE_CW + 1)'(r_alloc) + (NODE_CW + 1)'(2) >
                                         (NODE_CW + 1)'(MAX_NODES)) begin
                                n_res_valid = 1'b1;
                                n_res_err   = ERR_SHAPE_OVF;
                            end else begin
                                node_we    = 1'b1;
                                node_wdata = {1'b0, r_alloc[NODE_AW-1:0]};
                                n_alloc    = NODE_CW'(r_alloc + 2'd2);
                                n_shaped   = NODE_CW'(r_shaped + 1'b1);
                            end
                        end
                        KIND_CODE: begin
                            if (!complete) begin
                                n_res_valid = 1'b1;
                                n_res_err   = ERR_EARLY_CODE;
                            end else begin
                                n_bit   = i_cmd.bit_req;
                                n_state = ST_CUR_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LEAF_WR: begin
                node_we    = 1'b1;
                node_wdata = {2'b10, r_sym_rd};
                n_leaves   = SYM_CW'(r_leaves + 1'b1);
                n_shaped   = NODE_CW'(r_shaped + 1'b1);
                n_state    = ST_IDLE;
            end
            ST_CUR_RD: begin
                if (r_node_rd[NODE_W-1]) begin
                    // Only a one-leaf tree has a leaf as the current node.
                    n_res_valid = 1'b1;
                    n_res_sym   = r_node_rd[SYM_W-1:0];
                    n_cur       = '0;
                    n_state     = ST_IDLE;
                end else begin
                    node_raddr = child;
                    n_child    = child;
                    n_state    = ST_CHILD_RD;
                end
            end
            ST_CHILD_RD: begin
                if (r_node_rd[NODE_W-1]) begin
                    n_res_valid = 1'b1;
                    n_res_sym   = r_node_rd[SYM_W-1:0];
                    n_cur       = '0;
                end else begin
                    n_cur = r_child;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_loaded    <= '0;
            r_leaves    <= '0;
            r_shaped    <= '0;
            r_alloc     <= NODE_CW'(1);
            r_cur       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_leaves    <= n_leaves;
            r_shaped    <= n_shaped;
            r_alloc     <= n_alloc;
            r_cur       <= n_cur;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_child   <= n_child;
        r_bit     <= n_bit;
        r_res_sym <= n_res_sym;
        r_res_err <= n_res_err;
    end

    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            symbol_list[sym_waddr] <= i_cmd.sym;
        end
        r_sym_rd <= symbol_list[sym_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_table[node_waddr] <= node_wdata;
        end
        r_node_rd <= node_table[node_raddr];
    end

    assign o_res_valid = r_res_valid;
    assign o_res_sym   = r_res_sym;
    assign o_res_err   = r_res_err;

    a_err_zero_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_err != ERR_OK) |-> r_res_sym == '0)
        else $error("error result carries a symbol");

    a_leaves_le_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leaves <= r_loaded)
        else $error("more leaves than loaded symbols");

    a_shaped_le_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shaped <= r_alloc)
        else $error("more nodes shaped than allocated");

endmodule

// ----- src/huffman_tree_load_and_decode_core.sv -----
// Top level of the level-order Huffman tree loader and decoder.
// Depends on hftd_pkg, hftd_front and hftd_back.

// A request is taken at a rising edge where start is high and busy is low; it
// lands in a two-entry command queue, so busy rises only when that queue is
// full. The back end works through one command at a time. A symbol byte, a
// clear, an early code bit and an internal node or a failed shape bit finish in
// the idle state; a leaf waits in ST_LEAF_WR on the registered symbol list read,
// and any other code bit reads the current node in ST_CUR_RD and, unless the
// tree is a single leaf, its child in ST_CHILD_RD, each a registered read of
// the node table. A result appears on o_decoded_symbol and o_error_code for
// exactly one cycle with o_valid high, in the cycle after the back end decides
// it; the receiver cannot stall it, so it must take every strobed result. Only
// shape bits that fail and code bits produce results; on an error the symbol
// reads as zero. After a clear, the old symbol list and node table contents
// stay in place but are never read before being written again.
module huffman_tree_load_and_decode_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  logic       i_bit_req,
    input  logic [7:0] i_symbol,
    output logic       o_valid,
    output logic [7:0] o_decoded_symbol,
    output logic [1:0] o_error_code
);
    import hftd_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    t_err res_err;

    // The front end owns the handshake and the queue.
    hftd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_bit_req   (i_bit_req),
        .i_symbol    (i_symbol),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // The back end holds the tree and produces the registered results.
    hftd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (o_valid),
        .o_res_sym   (o_decoded_symbol),
        .o_res_err   (res_err)
    );

    assign o_error_code = res_err;

endmodule

// ----- tb/huffman_tree_load_and_decode_core_test.sv -----
// Self-checking testbench for huffman_tree_load_and_decode_core: directed table, then random trees.
// Depends on hftd_pkg and the core; predicts each decoded symbol and error itself unless a row carries it typed in.
module huffman_tree_load_and_decode_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hftd_pkg::*;

    // The directed part holds this many rows; the random part then runs until about
    // RANDOM_REQS further requests have been sent.
    localparam int DIRECTED_ROWS = 23;
    localparam int DIR_AW        = $clog2(DIRECTED_ROWS);
    localparam int RANDOM_REQS   = 1900;
    // STALL_LIMIT lies far beyond the longest a request takes in the core plus the longest
    // sender gap, so that long without any handshake or result means the core has hung.
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_LIMIT  = 10;

    // A row either leaves its outcome to the predictor or carries it typed in.
    typedef enum logic {
        CHK_MODEL  = 1'b0,
        CHK_RESULT = 1'b1
    } t_check;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        t_err             err;
    } t_decode;

    typedef struct packed {
        t_kind            kind;
        logic             bit_req;
        logic [SYM_W-1:0] sym;
        t_check           chk;
        logic [SYM_W-1:0] exp_sym;
        t_err             exp_err;
    } t_row;

    // Directed requests. The tree built here is a root with a leaf on the left and an
    // internal node on the right, whose own children are two leaves:
    //   code 0 -> 8'h00, code 10 -> 8'hFF, code 11 -> 8'hA5.
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // Nothing is loaded yet: a code bit is early and a leaf finds no symbol.
        '{KIND_CODE,   1'b1, 8'h00, CHK_RESULT, 8'h00, ERR_EARLY_CODE},
        '{KIND_SHAPE,  1'b1, 8'h00, CHK_RESULT, 8'h00, ERR_NO_SYMBOL},
        // Symbol list: both extremes and a mixed pattern.
        '{KIND_SYMBOL, 1'b1, 8'h00, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_SYMBOL, 1'b0, 8'hFF, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_SYMBOL, 1'b0, 8'hA5, CHK_MODEL,  8'h00, ERR_OK},
        // Shape the tree in level order.
        '{KIND_SHAPE,  1'b0, 8'h3C, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_SHAPE,  1'b1, 8'h00, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_SHAPE,  1'b0, 8'hFF, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_SHAPE,  1'b1, 8'h00, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_SHAPE,  1'b1, 8'h00, CHK_MODEL,  8'h00, ERR_OK},
        // The tree is complete, so one more shape bit overflows.
        '{KIND_SHAPE,  1'b0, 8'h00, CHK_RESULT, 8'h00, ERR_SHAPE_OVF},
        // Walk all three leaves.
        '{KIND_CODE,   1'b0, 8'h00, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_CODE,   1'b1, 8'h00, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_CODE,   1'b0, 8'hFF, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_CODE,   1'b1, 8'h00, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_CODE,   1'b1, 8'h00, CHK_MODEL,  8'h00, ERR_OK},
        // A clear throws the tree away, so code bits are early again.
        '{KIND_CLEAR,  1'b1, 8'hFF, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_CODE,   1'b0, 8'h00, CHK_RESULT, 8'h00, ERR_EARLY_CODE},
        // A tree of one leaf gives its symbol on every code bit.
        '{KIND_SYMBOL, 1'b0, 8'h5A, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_SHAPE,  1'b1, 8'h00, CHK_MODEL,  8'h00, ERR_OK},
        '{KIND_CODE,   1'b0, 8'h00, CHK_RESULT, 8'h5A, ERR_OK},
        '{KIND_CODE,   1'b1, 8'h00, CHK_RESULT, 8'h5A, ERR_OK},
        '{KIND_CLEAR,  1'b0, 8'h00, CHK_MODEL,  8'h00, ERR_OK}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_kind;
    logic             i_bit_req;
    logic [SYM_W-1:0] i_symbol;
    logic             o_valid;
    logic [SYM_W-1:0] o_decoded_symbol;
    logic [1:0]       o_error_code;

    // Driven together with each request so that the monitor knows, at the edge where
    // the request is taken, whether this row carries its own expected result.
    t_check  req_check;
    t_decode req_expect;

    // Predictor state: its own copy of the symbol list, the node table and the counters.
    logic [SYM_W-1:0]  mdl_symbols [MAX_SYMBOLS];
    logic [NODE_W-1:0] mdl_nodes   [MAX_NODES];
    int unsigned       mdl_loaded;
    int unsigned       mdl_leaves;
    int unsigned       mdl_shaped;
    int unsigned       mdl_alloc;
    int unsigned       mdl_walk;

    t_decode expected_decodes [$];

    int reqs_sent;
    int burst_left;
    int idle_cycles;
    int fail_count;

    huffman_tree_load_and_decode_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_bit_req        (i_bit_req),
        .i_symbol         (i_symbol),
        .o_valid          (o_valid),
        .o_decoded_symbol (o_decoded_symbol),
        .o_error_code     (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A clear leaves the list and the table in place; only the counters restart. The
    // walk never reads an entry that the current tree has not written.
    function automatic void clear_tree_model();
        mdl_loaded = 0;
        mdl_leaves = 0;
        mdl_shaped = 0;
        mdl_alloc  = 1;
        mdl_walk   = 0;
    endfunction

    // Applies one request to the predictor and returns 1 when it yields a result.
    function automatic logic predict_decode(input t_kind kind, input logic bit_req,
                                            input logic [SYM_W-1:0] sym,
                                            output t_decode res);
        logic [NODE_W-1:0] root;
        logic [NODE_W-1:0] node;
        int unsigned       child;
        logic              complete;
        complete = (mdl_shaped == mdl_alloc);
        res      = '{sym: '0, err: ERR_OK};
        case (kind)
            KIND_SYMBOL: begin
                // A full list drops further symbols without any result.
                if (mdl_loaded < MAX_SYMBOLS) begin
                    mdl_symbols[SYM_AW'(mdl_loaded)] = sym;
                    mdl_loaded++;
                end
                return 1'b0;
            end
            KIND_CLEAR: begin
                clear_tree_model();
                return 1'b0;
            end
            KIND_SHAPE: begin
                if (complete || mdl_shaped >= MAX_NODES) begin
                    res.err = ERR_SHAPE_OVF;
                    return 1'b1;
                end
                if (bit_req) begin
                    if (mdl_leaves >= mdl_loaded || mdl_leaves >= MAX_SYMBOLS) begin
                        res.err = ERR_NO_SYMBOL;
                        return 1'b1;
                    end
                    mdl_nodes[NODE_AW'(mdl_shaped)] = {2'b10, mdl_symbols[SYM_AW'(mdl_leaves)]};
                    mdl_leaves++;
                    mdl_shaped++;
                    return 1'b0;
                end
                // An internal node needs room for two children; otherwise it stays unshaped.
                if (mdl_alloc + 2 > MAX_NODES) begin
                    res.err = ERR_SHAPE_OVF;
                    return 1'b1;
                end
                mdl_nodes[NODE_AW'(mdl_shaped)] = {1'b0, mdl_alloc[8:0]};
                mdl_alloc  += 2;
                mdl_shaped++;
                return 1'b0;
            end
            default: begin
                if (!complete) begin
                    res.err = ERR_EARLY_CODE;
                    return 1'b1;
                end
                root = mdl_nodes[0];
                if (root[9]) begin
                    mdl_walk = 0;
                    res.sym  = root[7:0];
                    return 1'b1;
                end
                node = mdl_nodes[NODE_AW'(mdl_walk)];
                if (node[9])
                    node = root;
                child = 32'(node[8:0]) + 32'(bit_req);
                node  = (child < MAX_NODES) ? mdl_nodes[NODE_AW'(child)] : '0;
                if (node[9]) begin
                    mdl_walk = 0;
                    res.sym  = node[7:0];
                    return 1'b1;
                end
                mdl_walk = child & 9'h1FF;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [SYM_W-1:0] any_byte();
        return SYM_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input t_decode want);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s: expected symbol %02h error %0d, got symbol %02h error %0d",
                     $realtime, what, want.sym, want.err, o_decoded_symbol, o_error_code);
    endtask

    // Presents one request at a falling edge and holds it until the core takes it. The
    // sender works in bursts; when a burst runs out, start drops for a random gap.
    task automatic send_req(input t_kind kind, input logic bit_req,
                            input logic [SYM_W-1:0] sym, input t_check chk,
                            input logic [SYM_W-1:0] exp_sym, input t_err exp_err);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 24);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      <= 1'b1;
        i_kind     <= kind;
        i_bit_req  <= bit_req;
        i_symbol   <= sym;
        req_check  <= chk;
        req_expect <= '{sym: exp_sym, err: exp_err};
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
        burst_left--;
        reqs_sent++;
    endtask

    task automatic send_op(input t_kind kind, input logic bit_req, input logic [SYM_W-1:0] sym);
        send_req(kind, bit_req, sym, CHK_MODEL, 8'h00, ERR_OK);
    endtask

    // A stray request of any kind; mostly code and shape bits, some symbols, now and then a clear.
    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            send_op(KIND_CODE, coin(), any_byte());
        else if (pick < 7)
            send_op(KIND_SHAPE, coin(), any_byte());
        else if (pick < 9)
            send_op(KIND_SYMBOL, coin(), any_byte());
        else
            send_op(KIND_CLEAR, coin(), any_byte());
    endtask

    // Clears the core, loads symbols, shapes a random well-formed tree with the given
    // number of leaves in level order, then feeds random code bits through it. When
    // fewer symbols are preloaded than there are leaves, each leaf that finds none is
    // first tried bare (and refused), then given its symbol and shaped again.
    task automatic run_tree(input int leaves, input int preload, input int noise_pct,
                            input int codes);
        int   open_nodes;
        int   internals_left;
        int   leaves_done;
        int   loaded;
        logic make_leaf;
        logic probed;
        send_op(KIND_CLEAR, coin(), any_byte());
        repeat (preload)
            send_op(KIND_SYMBOL, coin(), any_byte());
        loaded         = preload;
        open_nodes     = 1;
        internals_left = leaves - 1;
        leaves_done    = 0;
        probed         = 1'b0;
        while (open_nodes > 0) begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_noise();
            if (internals_left == 0)
                make_leaf = 1'b1;
            else if (open_nodes == 1)
                make_leaf = 1'b0;
            else
                make_leaf = coin();
            if (make_leaf) begin
                // With every internal node of a full-size tree in place, the table
                // has no room for two more children.
                if (internals_left == 0 && leaves == MAX_SYMBOLS && !probed) begin
                    send_op(KIND_SHAPE, 1'b0, any_byte());
                    probed = 1'b1;
                end
                if (leaves_done >= loaded) begin
                    send_op(KIND_SHAPE, 1'b1, any_byte());
                    send_op(KIND_SYMBOL, coin(), any_byte());
                    loaded++;
                end
                send_op(KIND_SHAPE, 1'b1, any_byte());
                leaves_done++;
                open_nodes--;
            end else begin
                send_op(KIND_SHAPE, 1'b0, any_byte());
                internals_left--;
                open_nodes++;
            end
        end
        if ($urandom_range(0, 3) == 0)
            send_op(KIND_SHAPE, coin(), any_byte());
        repeat (codes) begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_noise();
            send_op(KIND_CODE, coin(), any_byte());
        end
    endtask

    // Monitor: results are checked first, so a request taken at the same edge cannot
    // be matched against a result that was already on the ports.
    always @(posedge i_clk) begin : monitor
        t_decode due;
        t_decode predicted;
        logic    produces;
        if (i_rst_n) begin
            idle_cycles++;
            if (o_valid) begin
                idle_cycles = 0;
                if (expected_decodes.size() == 0) begin
                    report_mismatch("result with none expected", '0);
                end else begin
                    due = expected_decodes.pop_front();
                    if (o_decoded_symbol !== due.sym || o_error_code !== due.err)
                        report_mismatch("wrong result", due);
                end
            end
            if (start && !busy) begin
                idle_cycles = 0;
                produces = predict_decode(t_kind'(i_kind), i_bit_req, i_symbol, predicted);
                if (req_check == CHK_RESULT)
                    expected_decodes.push_back(req_expect);
                else if (produces)
                    expected_decodes.push_back(predicted);
            end
        end
    end

    // Watchdog: ends the run once nothing has moved in either direction for too long.
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("huffman_tree_load_and_decode_core_test: done, errors");
        $finish;
    end

    initial begin
        int   leaves;
        int   preload;
        t_row row;
        start       = 1'b0;
        i_kind      = KIND_SYMBOL;
        i_bit_req   = 1'b0;
        i_symbol    = '0;
        req_check   = CHK_MODEL;
        req_expect  = '0;
        i_rst_n     = 1'b0;
        reqs_sent   = 0;
        burst_left  = 0;
        idle_cycles = 0;
        fail_count  = 0;
        for (int n = 0; n < MAX_SYMBOLS; n++)
            mdl_symbols[SYM_AW'(n)] = '0;
        for (int n = 0; n < MAX_NODES; n++)
            mdl_nodes[NODE_AW'(n)] = '0;
        clear_tree_model();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[DIR_AW'(r)];
            send_req(row.kind, row.bit_req, row.sym, row.chk, row.exp_sym, row.exp_err);
        end

        // One full-size tree: the symbol list overflows by a few bytes, all 256 leaves
        // and 255 internal nodes are shaped, and one internal node too many is refused.
        run_tree(MAX_SYMBOLS, MAX_SYMBOLS + 4, 0, 120);

        // Then many small trees, some short of symbols, some with stray requests mixed in.
        while (reqs_sent < DIRECTED_ROWS + RANDOM_REQS) begin
            leaves  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
            preload = ($urandom_range(0, 3) == 0) ? $urandom_range(0, leaves - 1) : leaves;
            run_tree(leaves, preload, coin() ? 0 : 6, $urandom_range(8, 40));
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 6))
                    send_noise();
        end
        start <= 1'b0;

        while (expected_decodes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("huffman_tree_load_and_decode_core_test: done, clean");
        else
            $display("huffman_tree_load_and_decode_core_test: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
src/hftd_pkg.sv
src/hftd_front.sv
src/hftd_back.sv
src/huffman_tree_load_and_decode_core.sv
tb/huffman_tree_load_and_decode_core_test.sv
